>>> rtl/core/rmcrw_pkg.sv
// Shared types, codes and sizes for the reliable multicast receive window.
// No dependencies; used by every module under rtl/core.
package rmcrw_pkg;

    localparam int WINDOW  = 128;
    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_RETRY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK   = 1'd1;

    localparam logic [31:0] RETRY_RESET = 32'd1000000;
    localparam logic [15:0] ACK_RESET   = 16'd10;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_HBEAT = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [1:0] OK_STATUS = 2'd0;
    localparam logic [1:0] OK_REQ    = 2'd1;
    localparam logic [1:0] OK_ACK    = 2'd2;

    localparam logic [2:0] ST_STORED = 3'd0;
    localparam logic [2:0] ST_OLD    = 3'd1;
    localparam logic [2:0] ST_DUP    = 3'd2;
    localparam logic [2:0] ST_OVF    = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] seq;
        logic [31:0] now_us;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [2:0]  status;
        logic [31:0] seq_out;
        logic [6:0]  slot;
        logic        write_payload;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        CLS_IGNORE,
        CLS_FLUSH,
        CLS_OLD,
        CLS_OVF,
        CLS_APPEND,
        CLS_IN_DATA,
        CLS_IN_HBEAT
    } t_cls;

    typedef enum logic [1:0] {
        RES_STATUS,
        RES_REQ,
        RES_ACK
    } t_res;

    typedef struct packed {
        logic       load;
        logic       mark_step;
        logic       mark_own;
        logic       fill_own;
        logic       rd_seq;
        logic       rd_edge;
        logic       flush;
        logic       set_st;
        logic [2:0] st;
        logic       slot_en;
        logic       edge_init;
        logic       edge_inc;
        logic       div_start;
        logic       div_step;
        logic       decide;
        logic       push;
        t_res       res;
    } t_cmd;

    typedef struct packed {
        t_cls cls;
        logic mark_done;
        logic edge_more;
        logic rd_bit;
        logic div_last;
        logic req;
        logic ack;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/core/rmcrw_ctrl.sv
// Sequencing state machine for the receive window.
// Depends on rmcrw_pkg; drives rmcrw_dp through command and status structs.
module rmcrw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  rmcrw_pkg::t_sts  i_sts,
    output rmcrw_pkg::t_cmd  o_cmd
);
    import rmcrw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CLASS, S_MARK, S_DUP, S_EDGE_INIT, S_EDGE_RD, S_EDGE_CHK,
        S_DIV, S_DECIDE, S_STATUS, S_REQ, S_ACK
    } t_state;

    t_state r_state, n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd   = '0;
        o_cmd.res = RES_STATUS;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                o_cmd.set_st = 1'b1;
                o_cmd.st = ST_STORED;
                o_cmd.slot_en = 1'b1;
                unique case (i_sts.cls)
                    CLS_IGNORE: n_state = S_IDLE;
                    CLS_FLUSH: begin
                        o_cmd.flush = 1'b1;
                        o_cmd.st = ST_FLUSH;
                        o_cmd.slot_en = 1'b0;
                        n_state = S_STATUS;
                    end
                    CLS_OLD: begin
                        o_cmd.st = ST_OLD;
                        o_cmd.slot_en = 1'b0;
                        n_state = S_STATUS;
                    end
                    CLS_OVF: begin
                        o_cmd.st = ST_OVF;
                        o_cmd.slot_en = 1'b0;
                        n_state = S_STATUS;
                    end
                    CLS_APPEND: n_state = S_MARK;
                    CLS_IN_DATA: begin
                        o_cmd.rd_seq = 1'b1;
                        n_state = S_DUP;
                    end
                    CLS_IN_HBEAT: n_state = S_EDGE_INIT;
                    default: n_state = S_IDLE;
                endcase
            end
            S_MARK: begin
                if (i_sts.mark_done) begin
                    o_cmd.mark_own = 1'b1;
                    n_state = S_EDGE_INIT;
                end else begin
                    o_cmd.mark_step = 1'b1;
                end
            end
            S_DUP: begin
                if (i_sts.rd_bit) begin
                    o_cmd.fill_own = 1'b1;
                    n_state = S_EDGE_INIT;
                end else begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st = ST_DUP;
                    o_cmd.slot_en = 1'b1;
                    n_state = S_STATUS;
                end
            end
            S_EDGE_INIT: begin
                o_cmd.edge_init = 1'b1;
                n_state = S_EDGE_RD;
            end
            S_EDGE_RD: begin
                if (i_sts.edge_more) begin
                    o_cmd.rd_edge = 1'b1;
                    n_state = S_EDGE_CHK;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_EDGE_CHK: begin
                if (i_sts.rd_bit) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_cmd.edge_inc = 1'b1;
                    n_state = S_EDGE_RD;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = S_STATUS;
            end
            S_STATUS: begin
                o_cmd.res = RES_STATUS;
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    if (i_sts.req)      n_state = S_REQ;
                    else if (i_sts.ack) n_state = S_ACK;
                    else                n_state = S_IDLE;
                end
            end
            S_REQ: begin
                o_cmd.res = RES_REQ;
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state = i_sts.ack ? S_ACK : S_IDLE;
                end
            end
            S_ACK: begin
                o_cmd.res = RES_ACK;
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> i_sts.out_free)
        else $error("push into a full output register");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_sts.div_last) |=> r_state == S_DIV)
        else $error("left the modulo loop early");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> r_state == S_CLASS)
        else $error("item accepted without classification");

endmodule

>>> rtl/core/rmcrw_dp.sv
// Datapath: window registers, slot missing memory, modulo unit, output register.
// Depends on rmcrw_pkg; steered by rmcrw_ctrl.
module rmcrw_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rmcrw_pkg::t_in_item           i_in_item,
    input  logic                          i_cfg_we,
    input  logic [rmcrw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                   i_cfg_data,
    input  rmcrw_pkg::t_cmd               i_cmd,
    output rmcrw_pkg::t_sts               o_sts,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output rmcrw_pkg::t_out_item          o_out_item
);
    import rmcrw_pkg::*;

    logic        mem [WINDOW];
    logic [1:0]  r_kind;
    logic [31:0] r_seq, r_now;
    logic [31:0] r_ws, r_nfs, r_contig, r_lrs, r_lrt;
    logic [31:0] r_retry;
    logic [15:0] r_ack_iv;
    logic [31:0] r_mark, r_edge, r_orig, r_quo;
    logic [16:0] r_rem;
    logic [4:0]  r_div_cnt;
    logic [2:0]  r_st;
    logic        r_slot_en, r_wp, r_req, r_ack, r_rd_bit;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [31:0] off, fill, nfs_m1, flush_tgt;
    logic [15:0] ai;
    logic [16:0] rem_sh;
    logic        gap, req_c, ack_c, out_free;
    logic [SLOT_W-1:0] rd_addr, wr_addr;
    logic        wr_en, wr_bit;
    t_cls        cls;

    assign off     = r_seq - r_ws;
    assign fill    = r_nfs - r_ws;
    assign nfs_m1  = r_nfs - 32'd1;
    assign ai      = (r_ack_iv == 16'd0) ? 16'd1 : r_ack_iv;
    assign rem_sh  = {r_rem[15:0], r_quo[31]};
    assign flush_tgt = (r_seq > r_nfs) ? r_nfs : r_seq;
    assign gap     = (r_nfs != 32'd0) && (r_edge < nfs_m1);
    assign req_c   = gap && (((r_now - r_lrt) > r_retry) || (r_edge != r_lrs));
    assign ack_c   = (r_rem == 17'd0) || ((r_edge - r_orig) > {16'd0, ai});
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        if (r_kind == KIND_NONE)            cls = CLS_IGNORE;
        else if (r_kind == KIND_FLUSH)      cls = CLS_FLUSH;
        else if (r_seq < r_ws)              cls = CLS_OLD;
        else if (off >= fill) begin
            if (off >= 32'(WINDOW) || r_seq == '1) cls = CLS_OVF;
            else                                  cls = CLS_APPEND;
        end else if (r_kind == KIND_DATA)   cls = CLS_IN_DATA;
        else                                cls = CLS_IN_HBEAT;
    end

    always_comb begin
        rd_addr = i_cmd.rd_edge ? r_edge[SLOT_W-1:0] : r_seq[SLOT_W-1:0];
        wr_en   = i_cmd.mark_step | i_cmd.mark_own | i_cmd.fill_own;
        wr_addr = i_cmd.mark_step ? r_mark[SLOT_W-1:0] : r_seq[SLOT_W-1:0];
        wr_bit  = i_cmd.mark_step | (i_cmd.mark_own & (r_kind == KIND_HBEAT));
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_bit;
        r_rd_bit <= mem[rd_addr];
    end

    always_comb begin
        o_sts.cls       = cls;
        o_sts.mark_done = (r_mark == r_seq);
        o_sts.edge_more = gap;
        o_sts.rd_bit    = r_rd_bit;
        o_sts.div_last  = (r_div_cnt == '1);
        o_sts.req       = r_req;
        o_sts.ack       = r_ack;
        o_sts.out_free  = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws        <= '0;
            r_nfs       <= '0;
            r_contig    <= '0;
            r_lrs       <= '0;
            r_lrt       <= '0;
            r_retry     <= RETRY_RESET;
            r_ack_iv    <= ACK_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RETRY: r_retry  <= i_cfg_data;
                    CFG_ACK:   r_ack_iv <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.flush && flush_tgt > r_ws) r_ws <= flush_tgt;
            if (i_cmd.mark_own) r_nfs <= r_seq + 32'd1;
            if (i_cmd.decide) begin
                r_contig <= r_edge;
                if (req_c) begin
                    r_lrs <= r_edge;
                    r_lrt <= r_now;
                end
            end
            if (i_cmd.push)            r_out_valid <= 1'b1;
            else if (!i_out_stall)     r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_in_item.kind;
            r_seq  <= i_in_item.seq;
            r_now  <= i_in_item.now_us;
            r_mark <= r_nfs;
            r_wp   <= 1'b0;
            r_req  <= 1'b0;
            r_ack  <= 1'b0;
        end
        if (i_cmd.mark_step) r_mark <= r_mark + 32'd1;
        if (i_cmd.mark_own)  r_wp <= (r_kind == KIND_DATA);
        if (i_cmd.fill_own)  r_wp <= 1'b1;
        if (i_cmd.set_st) begin
            r_st      <= i_cmd.st;
            r_slot_en <= i_cmd.slot_en;
        end
        if (i_cmd.edge_init) begin
            r_orig <= r_contig;
            r_edge <= (r_contig < r_ws) ? r_ws : r_contig;
        end
        if (i_cmd.edge_inc) r_edge <= r_edge + 32'd1;
        if (i_cmd.div_start) begin
            r_quo     <= r_edge;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_quo     <= {r_quo[30:0], 1'b0};
            r_rem     <= (rem_sh >= {1'b0, ai}) ? rem_sh - {1'b0, ai} : rem_sh;
            r_div_cnt <= r_div_cnt + 5'd1;
        end
        if (i_cmd.decide) begin
            r_req <= req_c;
            r_ack <= ack_c;
        end
        if (i_cmd.push) begin
            r_out.status        <= ST_STORED;
            r_out.seq_out       <= r_edge;
            r_out.slot          <= 7'(r_edge[SLOT_W-1:0]);
            r_out.write_payload <= 1'b0;
            case (i_cmd.res)
                RES_STATUS: begin
                    r_out.out_kind      <= OK_STATUS;
                    r_out.status        <= r_st;
                    r_out.seq_out       <= r_seq;
                    r_out.slot          <= r_slot_en ? 7'(r_seq[SLOT_W-1:0]) : 7'd0;
                    r_out.write_payload <= r_wp;
                    r_out.last          <= !(r_req || r_ack);
                end
                RES_REQ: begin
                    r_out.out_kind <= OK_REQ;
                    r_out.last     <= !r_ack;
                end
                default: begin
                    r_out.out_kind <= OK_ACK;
                    r_out.last     <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ws <= r_nfs)
        else $error("window start passed next free sequence");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nfs - r_ws) <= 32'(WINDOW))
        else $error("window fill exceeds depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.decide |=> r_contig >= r_ws)
        else $error("edge left behind window start");

endmodule

>>> rtl/core/reliable_multicast_receive_window.sv
// Receive window for one sequenced multicast stream: classifies data, heartbeat
// and flush items, tracks gaps in a 128-slot window and emits status, gap request
// and acknowledgement items. Depends on rmcrw_pkg, rmcrw_ctrl and rmcrw_dp.
// One item is handled at a time. Flush, old and overflow items go straight to the
// status output, waiting while it stalls; an unused kind is dropped; a duplicate is
// reported after one slot memory read. Other items make one slot memory write per
// skipped sequence, one memory read per edge step and a pass of the bit-serial
// modulo unit for the ack test, then emit their result items as the output frees.
module reliable_multicast_receive_window (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  rmcrw_pkg::t_in_item             i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output rmcrw_pkg::t_out_item            o_out_item,
    input  logic                            i_cfg_we,
    input  logic [rmcrw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                     i_cfg_data
);
    import rmcrw_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rmcrw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rmcrw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
